// ----- src/dirt_pkg.sv -----
// shared types and constants for the delayed repeat interval timer
// no dependencies; imported by every module of the block
package dirt_pkg;

  localparam int FIELD_TIME_W = 32;
  localparam int FIRE_NUM_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // opcodes of an input request
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd2;

  localparam logic [FIRE_NUM_W-1:0] FIRE_NUM_MAX = {FIRE_NUM_W{1'b1}};

  // controller -> datapath
  typedef struct packed {
    logic arm;
    logic tick_skip;
    logic tick_accum;
    logic fire;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stopped;
    logic skip_first;
    logic can_fire;
    logic last;
  } dp_stat_t;

  // one result item
  typedef struct packed {
    logic [FIELD_TIME_W-1:0] fire_time;
    logic [FIRE_NUM_W-1:0]   fire_number;
    logic                    finished;
    logic                    last_of_tick;
  } fire_t;

endpackage

// ----- src/dirt_in_if.sv -----
// input channel: tick or arm request with elapsed time
// depends on dirt_pkg
interface dirt_in_if
  import dirt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [FIELD_TIME_W-1:0] delta_time;

  modport source (output valid, output opcode, output delta_time, input ready);
  modport sink   (input valid, input opcode, input delta_time, output ready);
endinterface

// ----- src/dirt_out_if.sv -----
// result channel: one firing per transfer; a tick can yield several firings or none
// depends on dirt_pkg
interface dirt_out_if
  import dirt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [FIELD_TIME_W-1:0] fire_time;
  logic [FIRE_NUM_W-1:0]   fire_number;
  logic                    finished;
  logic                    last_of_tick;

  modport source (output valid, output fire_time, output fire_number, output finished,
                  output last_of_tick, input ready);
  modport sink   (input valid, input fire_time, input fire_number, input finished,
                  input last_of_tick, output ready);
endinterface

// ----- src/delayed_repeat_interval_timer_top.sv -----
// tick request: once accepted, one firing per cycle while the output register is free;
// the first result comes from the output register, loaded from the FIRE state
// a tick that fires holds the input not ready until its last firing, paced by the
// single compare-and-subtract unit; arm and ignored ticks do not leave the idle state
// synchronous active-low reset: timer armed, registers zero, no result pending
module delayed_repeat_interval_timer_top
  import dirt_pkg::*;
#(
  parameter int MAX_FIRES = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dirt_in_if.sink               in_chan,
  dirt_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  fire_t    fire, out_data;
  logic     out_free, in_ready;

  assign in_chan.ready = in_ready;

  dirt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  dirt_dp #(
    .MAX_FIRES (MAX_FIRES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .delta_time (in_chan.delta_time),
    .cmd        (cmd),
    .stat       (stat),
    .fire       (fire)
  );

  dirt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (cmd.fire),
    .fire      (fire),
    .out_free  (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.fire_time    = out_data.fire_time;
  assign out_chan.fire_number  = out_data.fire_number;
  assign out_chan.finished     = out_data.finished;
  assign out_chan.last_of_tick = out_data.last_of_tick;

endmodule

// ----- src/dirt_ctrl.sv -----
// controller state machine: request decode and firing sequence
// depends on dirt_pkg
module dirt_ctrl
  import dirt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  output logic     in_ready,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FIRE = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_ARM) begin
            cmd.arm = 1'b1;
          end else if (stat.stopped) begin
            // ignored until the next arm
          end else if (stat.skip_first) begin
            cmd.tick_skip = 1'b1;
          end else begin
            cmd.tick_accum = 1'b1;
            state_nxt      = ST_FIRE;
          end
        end
      end
      ST_FIRE: begin
        // only the first check of a tick can fail; later ones are looked ahead
        if (!stat.can_fire) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.fire = 1'b1;
          if (stat.last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- src/dirt_dp.sv -----
// datapath: config registers, elapsed accumulator, firing arithmetic
// depends on dirt_pkg
module dirt_dp
  import dirt_pkg::*;
#(
  parameter int MAX_FIRES = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [FIELD_TIME_W-1:0] delta_time,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output fire_t                   fire
);

  localparam int SUM_W = ((TIME_BITS > FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W) + 1;
  localparam int CNT_W = $clog2(MAX_FIRES + 1);
  localparam logic [SUM_W-1:0] TIME_MAX_X = SUM_W'({TIME_BITS{1'b1}});
  localparam logic [CNT_W-1:0] FIRES_LIM  = CNT_W'(MAX_FIRES - 1);

  logic [FIELD_TIME_W-1:0] interval_r, delay_r;
  logic [FIRE_NUM_W-1:0]   repeat_r;
  logic [TIME_BITS-1:0]    elapsed_r;
  logic                    skip_r, dly_pend_r, stopped_r;
  logic [FIRE_NUM_W-1:0]   cnt_r;
  logic [CNT_W-1:0]        fires_r;

  logic [SUM_W-1:0]      el_x, dly_x, ivl_x, iv_x, sub_x, sum_x, new_x, time_x;
  logic [TIME_BITS-1:0]  sum_sat, new_el;
  logic [FIRE_NUM_W-1:0] cnt_inc;
  logic                  fin, more_room, next_fires;

  always_comb begin
    el_x    = SUM_W'(elapsed_r);
    dly_x   = SUM_W'(delay_r);
    ivl_x   = SUM_W'(interval_r);
    // zero interval reports the whole elapsed time once
    iv_x    = (interval_r != '0) ? ivl_x : el_x;
    sub_x   = dly_pend_r ? dly_x : iv_x;
    time_x  = dly_pend_r ? el_x : iv_x;
    sum_x   = el_x + SUM_W'(delta_time);
    sum_sat = (sum_x > TIME_MAX_X) ? {TIME_BITS{1'b1}} : sum_x[TIME_BITS-1:0];
    new_el  = elapsed_r - sub_x[TIME_BITS-1:0];
    new_x   = SUM_W'(new_el);
    cnt_inc = (cnt_r != FIRE_NUM_MAX) ? cnt_r + 1'b1 : cnt_r;
    fin     = (repeat_r != '0) && (cnt_inc >= repeat_r);
    more_room = (fires_r < FIRES_LIM);
    // look ahead: will another firing follow in this tick
    if (dly_pend_r) next_fires = (interval_r == '0) || (new_x >= ivl_x);
    else            next_fires = (new_el != '0) && (new_x >= ivl_x);
    next_fires = next_fires && !fin && more_room;
  end

  assign stat.stopped    = stopped_r;
  assign stat.skip_first = skip_r;
  assign stat.can_fire   = (el_x >= sub_x);
  assign stat.last       = !next_fires;

  assign fire.fire_time    = time_x[FIELD_TIME_W-1:0];
  assign fire.fire_number  = cnt_inc;
  assign fire.finished     = fin;
  assign fire.last_of_tick = !next_fires;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      delay_r    <= '0;
      repeat_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL:     interval_r <= cfg_data;
        CFG_DELAY:        delay_r    <= cfg_data;
        CFG_REPEAT_COUNT: repeat_r   <= cfg_data[FIRE_NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      skip_r     <= 1'b1;
      dly_pend_r <= 1'b0;
      cnt_r      <= '0;
      stopped_r  <= 1'b0;
      fires_r    <= '0;
    end else if (cmd.arm) begin
      elapsed_r  <= '0;
      skip_r     <= 1'b1;
      dly_pend_r <= (delay_r != '0);
      cnt_r      <= '0;
      stopped_r  <= 1'b0;
    end else if (cmd.tick_skip) begin
      skip_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.tick_accum) begin
      elapsed_r <= sum_sat;
      fires_r   <= '0;
    end else if (cmd.fire) begin
      elapsed_r  <= new_el;
      dly_pend_r <= 1'b0;
      cnt_r      <= cnt_inc;
      stopped_r  <= fin;
      fires_r    <= fires_r + 1'b1;
    end
  end

endmodule

// ----- src/dirt_out_reg.sv -----
// output register holding one result request until taken
// depends on dirt_pkg
module dirt_out_reg
  import dirt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  fire_t fire,
  output logic  out_free,
  output logic  out_valid,
  input  logic  out_ready,
  output fire_t out_data
);

  logic  valid_r, valid_nxt;
  fire_t data_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= fire;
  end

endmodule

// ----- test/delayed_repeat_interval_timer_top_tb.sv -----
`timescale 1ns / 100ps
// testbench for delayed_repeat_interval_timer_top: directed and random tick and arm requests,
// every firing checked against a timer model kept inside the bench
// depends on dirt_pkg, dirt_in_if, dirt_out_if and the rtl top level
module delayed_repeat_interval_timer_top_tb;
  import dirt_pkg::*;

  localparam int FIRE_CAP = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [FIELD_TIME_W-1:0] TIME_SAT = {FIELD_TIME_W{1'b1}};

  typedef struct packed {
    logic                    opcode;
    logic [FIELD_TIME_W-1:0] delta_time;
  } timer_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dirt_in_if  in_chan ();
  dirt_out_if out_chan ();

  delayed_repeat_interval_timer_top #(
    .MAX_FIRES(FIRE_CAP),
    .TIME_BITS(FIELD_TIME_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // timer model: registers and state
  logic [FIELD_TIME_W-1:0] tm_interval = '0;
  logic [FIELD_TIME_W-1:0] tm_delay = '0;
  logic [FIRE_NUM_W-1:0]   tm_repeat = '0;
  logic [FIELD_TIME_W-1:0] tm_elapsed = '0;
  logic [FIRE_NUM_W-1:0]   tm_fired = '0;
  bit                      tm_skip = 1'b1;
  bit                      tm_delay_pend = 1'b0;
  bit                      tm_stopped = 1'b0;

  fire_t      expected_fires[$];
  timer_req_t pending_reqs[$];
  timer_req_t drv_req;
  fire_t      mon_want;
  fire_t      mon_got;
  int         issued = 0;
  int         accepted = 0;
  int         errors = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_steady = 1'b0;
  bit         out_steady = 1'b0;

  function automatic int draw_idle(input bit steady);
    return steady ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic bit count_firing();
    if (tm_fired != FIRE_NUM_MAX) tm_fired++;
    if (tm_repeat != '0 && tm_fired >= tm_repeat) begin
      tm_stopped = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_fire(logic [FIELD_TIME_W-1:0] t, bit fin);
    fire_t f;
    f.fire_time    = t;
    f.fire_number  = tm_fired;
    f.finished     = fin;
    f.last_of_tick = 1'b0;
    expected_fires = {expected_fires, f};
  endfunction

  function automatic void mark_last_of_tick();
    fire_t f;
    int    idx;
    idx = expected_fires.size() - 1;
    f = expected_fires[idx];
    f.last_of_tick = 1'b1;
    expected_fires[idx] = f;
  endfunction

  function automatic void predict_firings(logic op, logic [FIELD_TIME_W-1:0] dt);
    int                      n;
    logic [FIELD_TIME_W:0]   sum;
    logic [FIELD_TIME_W-1:0] step;
    bit                      fin;
    n   = 0;
    fin = 1'b0;
    if (op == OP_ARM) begin
      tm_elapsed    = '0;
      tm_skip       = 1'b1;
      tm_delay_pend = (tm_delay != '0);
      tm_fired      = '0;
      tm_stopped    = 1'b0;
      return;
    end
    if (tm_stopped) return;
    // first tick after arm only clears the skip flag and the firing count
    if (tm_skip) begin
      tm_skip  = 1'b0;
      tm_fired = '0;
      return;
    end
    sum = {1'b0, tm_elapsed} + {1'b0, dt};
    tm_elapsed = sum[FIELD_TIME_W] ? TIME_SAT : sum[FIELD_TIME_W-1:0];
    if (tm_delay_pend) begin
      if (tm_elapsed < tm_delay) return;
      fin = count_firing();
      push_fire(tm_elapsed, fin);
      n++;
      tm_elapsed    = tm_elapsed - tm_delay;
      tm_delay_pend = 1'b0;
      if (fin) begin
        mark_last_of_tick();
        return;
      end
    end
    // zero interval consumes the whole elapsed time in one firing
    step = (tm_interval != '0) ? tm_interval : tm_elapsed;
    while (!fin && n < FIRE_CAP && tm_elapsed >= step) begin
      fin = count_firing();
      push_fire(step, fin);
      n++;
      tm_elapsed = tm_elapsed - step;
      if (tm_elapsed == '0) break;
    end
    if (n > 0) mark_last_of_tick();
  endfunction

  function automatic void queue_req(logic op, logic [FIELD_TIME_W-1:0] dt);
    timer_req_t r;
    r.opcode     = op;
    r.delta_time = dt;
    pending_reqs = {pending_reqs, r};
    issued++;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_INTERVAL:     tm_interval = data;
      CFG_DELAY:        tm_delay = data;
      CFG_REPEAT_COUNT: tm_repeat = data[FIRE_NUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every request to be taken and every firing to come back, then let the
  // block finish a tick that fires nothing
  task automatic drain();
    while (accepted != issued || expected_fires.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid      <= 1'b0;
      in_chan.opcode     <= OP_TICK;
      in_chan.delta_time <= '0;
      in_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_firings(in_chan.opcode, in_chan.delta_time);
        accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drv_req = pending_reqs[0];
          pending_reqs.delete(0);
          in_chan.valid      <= 1'b1;
          in_chan.opcode     <= drv_req.opcode;
          in_chan.delta_time <= drv_req.delta_time;
          if ($urandom_range(0, 15) == 0) in_steady = !in_steady;
          in_gap = draw_idle(in_steady);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // firing monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        mon_got.fire_time    = out_chan.fire_time;
        mon_got.fire_number  = out_chan.fire_number;
        mon_got.finished     = out_chan.finished;
        mon_got.last_of_tick = out_chan.last_of_tick;
        if (expected_fires.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected firing: time %h number %0d finished %b last %b",
                     mon_got.fire_time, mon_got.fire_number, mon_got.finished,
                     mon_got.last_of_tick);
        end else begin
          mon_want = expected_fires[0];
          expected_fires.delete(0);
          if (mon_got !== mon_want) begin
            errors++;
            if (errors <= 10) begin
              $display("firing mismatch: expected time %h number %0d finished %b last %b",
                       mon_want.fire_time, mon_want.fire_number, mon_want.finished,
                       mon_want.last_of_tick);
              $display("                 got time %h number %0d finished %b last %b",
                       mon_got.fire_time, mon_got.fire_number, mon_got.finished,
                       mon_got.last_of_tick);
            end
          end
        end
        if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
        out_stall = draw_idle(out_steady);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("delayed_repeat_interval_timer_top_tb NOT OK");
    $finish;
  end

  initial begin
    int                      p;
    int                      k;
    logic [FIELD_TIME_W-1:0] iv;
    logic [FIELD_TIME_W-1:0] dl;
    logic [FIELD_TIME_W-1:0] dt;
    logic [FIRE_NUM_W-1:0]   rc;
    longint unsigned         lim;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: zero interval, armed so the first tick is dropped
    queue_req(OP_TICK, 32'h1234_5678);
    queue_req(OP_TICK, 32'h0000_0000);
    queue_req(OP_TICK, 32'hFFFF_FFFF);
    queue_req(OP_TICK, 32'h0000_0001);
    drain();

    // delay phase, interval firings, stop at repeat count, write to unused index
    cfg_write(CFG_INTERVAL, 32'h0001_0000);
    cfg_write(CFG_DELAY, 32'h0003_0000);
    cfg_write(CFG_REPEAT_COUNT, 32'hFFFF_0005);
    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg_done();
    queue_req(OP_ARM, 32'hFFFF_FFFF);
    queue_req(OP_TICK, 32'h0005_0000);
    queue_req(OP_TICK, 32'h0002_0000);
    queue_req(OP_TICK, 32'h0001_8000);
    queue_req(OP_TICK, 32'h0003_0000);
    queue_req(OP_TICK, 32'h0001_0000);
    queue_req(OP_TICK, 32'hFFFF_FFFF);
    drain();

    // firing cap with time left over for the next tick
    cfg_write(CFG_INTERVAL, 32'h0000_0001);
    cfg_write(CFG_DELAY, 32'h0000_0000);
    cfg_write(CFG_REPEAT_COUNT, 32'h0000_0000);
    cfg_done();
    queue_req(OP_ARM, 32'h0000_0000);
    queue_req(OP_TICK, 32'h0000_0000);
    queue_req(OP_TICK, 32'h0000_0064);
    queue_req(OP_TICK, 32'h0000_0000);
    drain();

    // repeat count lowered below the firings already made
    cfg_write(CFG_REPEAT_COUNT, 32'h0000_0001);
    cfg_done();
    queue_req(OP_TICK, 32'h0000_0005);
    drain();

    // largest registers: accumulator saturates to reach the delay
    cfg_write(CFG_INTERVAL, 32'hFFFF_FFFF);
    cfg_write(CFG_DELAY, 32'hFFFF_FFFF);
    cfg_write(CFG_REPEAT_COUNT, 32'h0000_FFFF);
    cfg_done();
    queue_req(OP_ARM, 32'h0000_0000);
    queue_req(OP_TICK, 32'h0000_0000);
    queue_req(OP_TICK, 32'h8000_0000);
    queue_req(OP_TICK, 32'h9000_0000);
    queue_req(OP_TICK, 32'hFFFF_FFFF);
    drain();

    // delay firing that also reaches the repeat count
    cfg_write(CFG_INTERVAL, 32'h0000_0000);
    cfg_write(CFG_DELAY, 32'h0000_8000);
    cfg_write(CFG_REPEAT_COUNT, 32'h0000_0001);
    cfg_done();
    queue_req(OP_ARM, 32'h0000_0000);
    queue_req(OP_TICK, 32'h0000_0000);
    queue_req(OP_TICK, 32'h0001_0000);
    queue_req(OP_TICK, 32'h0001_0000);
    drain();

    for (p = 0; p < 12; p++) begin
      case ($urandom_range(0, 5))
        0: iv = '0;
        1: iv = $urandom_range(1, 16);
        2: iv = $urandom_range(1, 32'h0004_0000);
        3: iv = $urandom;
        4: iv = TIME_SAT;
        default: iv = $urandom_range(32'h0000_8000, 32'h0002_0000);
      endcase
      case ($urandom_range(0, 4))
        0, 1: dl = '0;
        2, 3: dl = $urandom_range(1, 32'h0008_0000);
        default: dl = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: rc = '0;
        1: rc = 16'd1;
        2: rc = 16'($urandom_range(2, 40));
        3: rc = FIRE_NUM_MAX;
        default: rc = 16'($urandom_range(0, 65535));
      endcase
      cfg_write(CFG_INTERVAL, iv);
      cfg_write(CFG_DELAY, dl);
      cfg_write(CFG_REPEAT_COUNT, {16'($urandom_range(0, 65535)), rc});
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, $urandom);
      cfg_done();

      queue_req(OP_ARM, $urandom);
      for (k = 0; k < 32; k++) begin
        // mostly deltas near the interval so firings stay frequent
        case ($urandom_range(0, 9))
          0: dt = '0;
          1: dt = TIME_SAT;
          2, 3: dt = $urandom;
          default: begin
            lim = (tm_interval == '0) ? 64'h0002_0000 : 64'(tm_interval) * 3;
            if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
            dt = $urandom_range(0, lim[31:0]);
          end
        endcase
        if ($urandom_range(0, 15) == 0) queue_req(OP_ARM, dt);
        else queue_req(OP_TICK, dt);
      end
      drain();
    end

    if (errors == 0) begin
      $display("delayed_repeat_interval_timer_top_tb OK");
    end else begin
      $display("delayed_repeat_interval_timer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
